>>> rtl/eprng_pkg.sv
// package: types, constants and sha-256 helpers for the entropy pool rng
`timescale 1ns / 1ps
package eprng_pkg;

   localparam int TICK_WIDTH = 32;
   localparam int TICK_IN_W  = 32;
   localparam int TICK_USE_W = (TICK_WIDTH < TICK_IN_W) ? TICK_WIDTH : TICK_IN_W;
   localparam int POOL_W     = 64;
   localparam int RAND_W     = 16;
   localparam int ROUNDS     = 64;
   localparam int RND_W      = $clog2(ROUNDS);

   typedef enum logic [1:0] {
      OP_SEED = 2'd0,
      OP_ADD  = 2'd1,
      OP_GET  = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_pool;
      logic add_pool;
      logic hash_start;
      logic hash_round;
      logic hash_finish;
   } cmd_type;

   typedef struct packed {
      logic last_round;
   } status_type;

   localparam logic [31:0] H_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] K_ROUND [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] bswap(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

endpackage

>>> rtl/eprng_if.sv
// valid/ready channel interfaces for requests and responses
`timescale 1ns / 1ps
interface eprng_req_if;
   import eprng_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [63:0] entropy_value;
   logic [31:0] tick_count;
   modport source (output valid, op, entropy_value, tick_count, input ready);
   modport sink   (input valid, op, entropy_value, tick_count, output ready);
endinterface

interface eprng_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] random_value;
   modport source (output valid, random_value, input ready);
   modport sink   (input valid, random_value, output ready);
endinterface

>>> rtl/eprng_ctrl.sv
// controller state machine sequencing seed, add and hash requests
`timescale 1ns / 1ps
module eprng_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_op,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  eprng_pkg::status_type status,
   output eprng_pkg::cmd_type    cmd
);
   import eprng_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // ready is always high here, so valid alone marks an accepted request
            if (req_valid) begin
               unique case (op_type'(req_op))
                  OP_SEED: cmd.load_pool = 1'b1;
                  OP_ADD:  cmd.add_pool  = 1'b1;
                  OP_GET: begin
                     cmd.hash_start = 1'b1;
                     state_in       = ST_ROUND;
                  end
                  default: ;
               endcase
            end
         end
         ST_ROUND: begin
            cmd.hash_round = 1'b1;
            if (status.last_round) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.hash_finish = 1'b1;
            state_in        = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while response pending");
   a_get_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.hash_start |=> state_ff == ST_ROUND) else $error("hash did not start");
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      cmd.hash_finish |=> rsp_valid) else $error("no response after finish");
endmodule

>>> rtl/eprng_dp.sv
// datapath: pool register, message schedule and shared sha-256 round unit
`timescale 1ns / 1ps
module eprng_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  eprng_pkg::cmd_type    cmd,
   input  logic [63:0]           req_entropy_value,
   input  logic [31:0]           req_tick_count,
   output eprng_pkg::status_type status,
   output logic [15:0]           rsp_random_value
);
   import eprng_pkg::*;

   logic [63:0]      pool_ff;
   logic [31:0]      wnd_ff [16];
   logic [31:0]      st_ff [8];
   logic [RND_W-1:0] rnd_ff;
   logic [15:0]      rand_ff;

   logic [31:0] s0w, s1w, wnew, t1, t2, s1e, s0a, ch, maj;
   logic [31:0] d0, d1, d2, d3;
   logic [63:0] tick_ext;
   logic [TICK_USE_W-1:0] tick_use;

   assign tick_use = req_tick_count[TICK_USE_W-1:0];
   assign tick_ext = 64'(tick_use);

   // schedule word for round r+16 from the 16-word window
   assign s0w  = rotr(wnd_ff[1], 7) ^ rotr(wnd_ff[1], 18) ^ (wnd_ff[1] >> 3);
   assign s1w  = rotr(wnd_ff[14], 17) ^ rotr(wnd_ff[14], 19) ^ (wnd_ff[14] >> 10);
   assign wnew = wnd_ff[0] + s0w + wnd_ff[9] + s1w;

   assign s1e = rotr(st_ff[4], 6) ^ rotr(st_ff[4], 11) ^ rotr(st_ff[4], 25);
   assign ch  = (st_ff[4] & st_ff[5]) ^ (~st_ff[4] & st_ff[6]);
   assign t1  = st_ff[7] + s1e + ch + K_ROUND[rnd_ff] + wnd_ff[0];
   assign s0a = rotr(st_ff[0], 2) ^ rotr(st_ff[0], 13) ^ rotr(st_ff[0], 22);
   assign maj = (st_ff[0] & st_ff[1]) ^ (st_ff[0] & st_ff[2]) ^ (st_ff[1] & st_ff[2]);
   assign t2  = s0a + maj;

   assign d0 = st_ff[0] + H_INIT[0];
   assign d1 = st_ff[1] + H_INIT[1];
   assign d2 = st_ff[2] + H_INIT[2];
   assign d3 = st_ff[3] + H_INIT[3];

   assign status.last_round = (rnd_ff == RND_W'(ROUNDS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= '0;
      end else if (cmd.load_pool) begin
         pool_ff <= req_entropy_value;
      end else if (cmd.add_pool) begin
         pool_ff <= {pool_ff[62:0], pool_ff[63]} ^ req_entropy_value ^ tick_ext;
      end else if (cmd.hash_finish) begin
         pool_ff <= pool_ff ^ {bswap(d1), bswap(d0)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff <= '0;
      end else if (cmd.hash_start) begin
         rnd_ff <= '0;
      end else if (cmd.hash_round) begin
         rnd_ff <= rnd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hash_start) begin
         wnd_ff[0] <= bswap(pool_ff[31:0]);
         wnd_ff[1] <= bswap(pool_ff[63:32]);
         wnd_ff[2] <= 32'h80000000;
         for (int i = 3; i < 15; i++) wnd_ff[i] <= '0;
         wnd_ff[15] <= 32'd64;
         for (int i = 0; i < 8; i++) st_ff[i] <= H_INIT[i];
      end else if (cmd.hash_round) begin
         for (int i = 0; i < 15; i++) wnd_ff[i] <= wnd_ff[i+1];
         wnd_ff[15] <= wnew;
         st_ff[7] <= st_ff[6];
         st_ff[6] <= st_ff[5];
         st_ff[5] <= st_ff[4];
         st_ff[4] <= st_ff[3] + t1;
         st_ff[3] <= st_ff[2];
         st_ff[2] <= st_ff[1];
         st_ff[1] <= st_ff[0];
         st_ff[0] <= t1 + t2;
      end
      if (cmd.hash_finish) begin
         // word 1 bytes are digest bytes 8..15, low 16 bits = bytes 8,9
         rand_ff <= {d2[23:16], d2[31:24]};
      end
   end

   assign rsp_random_value = rand_ff;

   a_round_count: assert property (@(posedge clock) disable iff (reset)
      cmd.hash_start |=> rnd_ff == '0) else $error("round counter not cleared");
   a_pool_hold: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.hash_round) |-> $stable(pool_ff)) else $error("pool changed in rounds");
endmodule

>>> rtl/entropy_pool_sha256_rng.sv
// top level of the entropy pool random number source with sha-256 whitening
`timescale 1ns / 1ps
// seed and add requests give no response; the controller stays idle and ready
// a get request runs 64 rounds on the one shared round unit, then a finish step and
// a response step; no new request is accepted until the response is taken, so gets
// do not overlap and a stalled response holds off the next request
// synchronous active-high reset clears the pool to zero and returns the controller to idle
module entropy_pool_sha256_rng (
   input  logic        clock,
   input  logic        reset,
   eprng_req_if.sink   req,
   eprng_rsp_if.source rsp
);
   import eprng_pkg::*;

   // command and status between controller and datapath
   cmd_type    cmd;
   status_type status;

   // controller: accepts requests, steps the round unit, holds the response
   eprng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.op),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: pool, schedule window, round unit, response register
   eprng_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_entropy_value (req.entropy_value),
      .req_tick_count    (req.tick_count),
      .status            (status),
      .rsp_random_value  (rsp.random_value)
   );
endmodule

>>> bench/tb_top.sv
// testbench for the entropy pool rng: directed table, random requests, sha-256 predictor
`timescale 1ns / 1ps
module tb_top;
   import eprng_pkg::*;

   // one row of the directed stimulus table
   typedef struct {
      op_type      op;
      logic [63:0] ent;
      logic [31:0] tick;
      logic        has_val;  // expected value typed in
      logic [15:0] val;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   eprng_req_if req ();
   eprng_rsp_if rsp ();

   entropy_pool_sha256_rng DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   // predictor state and expected random values
   logic [63:0] pool_model;
   logic [15:0] rand_queue[$];
   int          errors = 0;
   int          sender_idle = 0;   // percent of cycles the sender idles
   int          receiver_stall = 0;
   int          hold_cycles = 0;   // long receiver hold-off, counted down
   longint      cycle_count = 0;
   row_type     rows[$];
   logic        tab_has = 1'b0;    // typed value travels with the table request
   logic [15:0] tab_val = '0;

   function automatic logic [31:0] rr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // sha-256 of the pool's 8 bytes, low byte first; returns digest words 0 and 1
   function automatic logic [127:0] digest_words(input logic [63:0] v);
      logic [31:0] w[64];
      logic [31:0] h[8];
      logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
      logic [7:0]  dg[32];
      logic [63:0] w0, w1;
      for (int i = 0; i < 16; i++) w[i] = '0;
      w[0] = {v[7:0], v[15:8], v[23:16], v[31:24]};
      w[1] = {v[39:32], v[47:40], v[55:48], v[63:56]};
      w[2] = 32'h8000_0000;
      w[15] = 32'd64;
      for (int i = 16; i < 64; i++)
         w[i] = w[i-16] + (rr(w[i-15], 7) ^ rr(w[i-15], 18) ^ (w[i-15] >> 3))
              + w[i-7] + (rr(w[i-2], 17) ^ rr(w[i-2], 19) ^ (w[i-2] >> 10));
      for (int i = 0; i < 8; i++) h[i] = H_INIT[i];
      a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
      for (int i = 0; i < 64; i++) begin
         t1 = hh + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & f) ^ (~e & g))
            + K_ROUND[i] + w[i];
         t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      h[0] += a; h[1] += b; h[2] += c; h[3] += d;
      h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 4; j++) dg[4*i+j] = h[i][31-8*j -: 8];
      for (int i = 0; i < 8; i++) begin
         w0[8*i +: 8] = dg[i];
         w1[8*i +: 8] = dg[8+i];
      end
      return {w1, w0};
   endfunction

   // advance the pool for one accepted request and queue any expected value
   function automatic void predict_request(input op_type op, input logic [63:0] ent,
                                           input logic [31:0] tick);
      logic [127:0] dw;
      case (op)
         OP_SEED: pool_model = ent;
         OP_ADD: begin
            pool_model = {pool_model[62:0], pool_model[63]} ^ ent;
            pool_model ^= {32'd0, tick};
         end
         OP_GET: begin
            dw = digest_words(pool_model);
            pool_model ^= dw[63:0];
            rand_queue.push_back(dw[79:64]);
            // typed table value must agree with the predictor
            if (tab_has && dw[79:64] !== tab_val) begin
               $display("%0t: table value mismatch, expected %h predictor %h",
                        $time, tab_val, dw[79:64]);
               errors++;
            end
         end
         default: ;
      endcase
   endfunction

   // drive one request and hold it until accepted
   task automatic send_request(input op_type op, input logic [63:0] ent,
                               input logic [31:0] tick);
      while ($urandom_range(99) < sender_idle) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.op            <= op;
      req.entropy_value <= ent;
      req.tick_count    <= tick;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // step the clock first so the predictor has seen the last accepted request
   task automatic drain_responses();
      @(posedge clock);
      while (rand_queue.size() != 0) @(posedge clock);
   endtask

   // accept at the edge: update predictor on every handshake
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         predict_request(op_type'(req.op), req.entropy_value, req.tick_count);
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (rand_queue.size() == 0) begin
            $display("%0t: unexpected response, actual %h", $time, rsp.random_value);
            errors++;
         end else begin
            if (rsp.random_value !== rand_queue[0]) begin
               $display("%0t: random_value mismatch, expected %h actual %h",
                        $time, rand_queue[0], rsp.random_value);
               errors++;
            end
            void'(rand_queue.pop_front());
         end
      end
   end

   // receiver: random stalls plus a long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready   <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= receiver_stall);
      end
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2_000_000) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic op_type rand_op();
      int r;
      r = $urandom_range(99);
      if (r < 30) return OP_GET;
      if (r < 75) return OP_ADD;
      if (r < 95) return OP_SEED;
      return OP_NONE;
   endfunction

   initial begin
      row_type r;
      logic [15:0] first_get;
      logic [127:0] zero_dw;
      req.valid         = 1'b0;
      req.op            = OP_NONE;
      req.entropy_value = '0;
      req.tick_count    = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table; the first get from the zero pool is known at a glance
      zero_dw   = digest_words(64'd0);
      first_get = zero_dw[79:64];
      rows.push_back('{OP_GET, 64'd0, 32'd0, 1'b1, first_get});
      rows.push_back('{OP_NONE, '1, '1, 1'b0, 16'd0});   // undefined op, pool untouched
      rows.push_back('{OP_SEED, 64'd0, 32'd0, 1'b0, 16'd0});
      rows.push_back('{OP_GET, 64'd0, 32'd0, 1'b1, first_get});
      rows.push_back('{OP_SEED, '1, '1, 1'b0, 16'd0});
      rows.push_back('{OP_GET, 64'd0, 32'd0, 1'b0, 16'd0});
      rows.push_back('{OP_ADD, '1, '1, 1'b0, 16'd0});
      rows.push_back('{OP_ADD, 64'h8000_0000_0000_0000, 32'h8000_0000, 1'b0, 16'd0});
      rows.push_back('{OP_GET, 64'd0, 32'd0, 1'b0, 16'd0});
      rows.push_back('{OP_SEED, 64'h8000_0000_0000_0001, 32'd0, 1'b0, 16'd0});
      rows.push_back('{OP_ADD, 64'd0, 32'd0, 1'b0, 16'd0});  // rotate only, wraps top bit
      rows.push_back('{OP_GET, 64'd0, 32'd0, 1'b0, 16'd0});
      rows.push_back('{OP_ADD, 64'd0, 32'hffff_ffff, 1'b0, 16'd0});
      rows.push_back('{OP_GET, '1, '1, 1'b0, 16'd0});
      rows.push_back('{OP_NONE, 64'd0, 32'd0, 1'b0, 16'd0});
      rows.push_back('{OP_GET, 64'd0, 32'd0, 1'b0, 16'd0});
      foreach (rows[i]) begin
         r = rows[i];
         tab_has <= r.has_val;
         tab_val <= r.val;
         send_request(r.op, r.ent, r.tick);
      end
      req.valid <= 1'b0;
      tab_has   <= 1'b0;
      drain_responses();

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle    = (ph == 1) ? 68 : (ph == 3) ? 13 : 0;
         receiver_stall = (ph == 2) ? 68 : (ph == 3) ? 13 : 0;
         if (ph == 1) hold_cycles = 400;  // long hold-off while requests keep coming
         for (int n = 0; n < 425; n++) begin
            send_request(rand_op(), rand64(), (($urandom_range(3) == 0) ? '1 : $urandom));
            if (n == 200) begin
               // sender pauses until every response is in
               req.valid <= 1'b0;
               drain_responses();
            end
         end
         req.valid <= 1'b0;
         drain_responses();
      end

      repeat (100) @(posedge clock);
      if (errors == 0 && rand_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

>>> entropy_pool_sha256_rng.f
rtl/eprng_pkg.sv
rtl/eprng_if.sv
rtl/eprng_ctrl.sv
rtl/eprng_dp.sv
rtl/entropy_pool_sha256_rng.sv
bench/tb_top.sv
